/* rtl/core/fofg_pkg.sv */
// shared constants, codes and types of the friends-of-friends grouper
// no dependencies; fofg_ifs, fofg_dist_cell, fofg_dist_chain and the top level refer to it by scoped name
package fofg_pkg;

  localparam int DEF_MAX_PARTICLES = 4096;
  localparam int DEF_COORD_BITS    = 24;

  localparam int LINK_W    = 50;
  localparam int EDGE_W    = 23;
  localparam int FIRST_W   = 12;
  localparam int SECOND_W  = 13;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int AXES      = 3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GROUP = 2'd0,
    KIND_SLOT  = 2'd1,
    KIND_NONE  = 2'd2
  } rec_kind_e;

endpackage

/* rtl/core/fofg_ifs.sv */
// valid/ready channel interfaces of the grouper: particle items, result records, config writes
// depends on fofg_pkg for field widths
interface fofg_item_if #(
  parameter int CB = fofg_pkg::DEF_COORD_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic signed [CB-1:0] pos_x;
  logic signed [CB-1:0] pos_y;
  logic signed [CB-1:0] pos_z;
  logic                 last_particle;

  modport source (output valid, opcode, pos_x, pos_y, pos_z, last_particle, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, pos_z, last_particle, output ready);
endinterface

interface fofg_rec_if #(
  parameter int CB = fofg_pkg::DEF_COORD_BITS
);
  logic                             valid;
  logic                             ready;
  logic [fofg_pkg::KIND_W-1:0]      record_kind;
  logic [fofg_pkg::FIRST_W-1:0]     first_value;
  logic [fofg_pkg::SECOND_W-1:0]    second_value;
  logic signed [CB-1:0]             box_min_x;
  logic signed [CB-1:0]             box_min_y;
  logic signed [CB-1:0]             box_min_z;
  logic signed [CB-1:0]             box_max_x;
  logic signed [CB-1:0]             box_max_y;
  logic signed [CB-1:0]             box_max_z;
  logic                             last_record;

  modport source (output valid, record_kind, first_value, second_value, box_min_x, box_min_y,
                  box_min_z, box_max_x, box_max_y, box_max_z, last_record, input ready);
  modport sink   (input valid, record_kind, first_value, second_value, box_min_x, box_min_y,
                  box_min_z, box_max_x, box_max_y, box_max_z, last_record, output ready);
endinterface

interface fofg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fofg_pkg::CFG_IDX_W-1:0] index;
  logic [fofg_pkg::LINK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fofg_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module fofg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fofg_dist_cell.sv */
// one cell of the distance chain: adds the square of its axis difference to the running sum
// and hands the sum and the remaining differences to the next cell; uses fofg_pkg
module fofg_dist_cell #(
  parameter int CB    = fofg_pkg::DEF_COORD_BITS,
  parameter int SUM_W = 2 * CB + 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [SUM_W-1:0]                     sum_i,
  input  logic [fofg_pkg::AXES-1:0][CB-1:0]    diff_i,
  output logic                                 valid_o,
  output logic [SUM_W-1:0]                     sum_o,
  output logic [fofg_pkg::AXES-1:0][CB-1:0]    diff_o
);

  localparam int SQ_W = 2 * CB;

  logic [SQ_W-1:0]                      sq;
  logic                                 valid_q;
  logic [SUM_W-1:0]                     sum_q;
  logic [fofg_pkg::AXES-1:0][CB-1:0]    diff_q;

  assign sq = SQ_W'(diff_i[0]) * SQ_W'(diff_i[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_i + SUM_W'(sq);
    diff_q <= {CB'(0), diff_i[fofg_pkg::AXES-1:1]};
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign diff_o  = diff_q;

endmodule

/* rtl/core/fofg_dist_chain.sv */
// squared-distance chain: absolute differences, one cell per axis, then the link compare
// depends on fofg_pkg and fofg_dist_cell
module fofg_dist_chain #(
  parameter int CB = fofg_pkg::DEF_COORD_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [fofg_pkg::AXES-1:0][CB-1:0]    a_i,
  input  logic [fofg_pkg::AXES-1:0][CB-1:0]    b_i,
  input  logic [fofg_pkg::LINK_W-1:0]          link_len_i,
  output logic                                 done_o,
  output logic                                 link_o
);

  localparam int SUM_W = 2 * CB + 2;
  localparam int CMP_W = (SUM_W > fofg_pkg::LINK_W) ? SUM_W : fofg_pkg::LINK_W;
  localparam int NA    = fofg_pkg::AXES;

  logic [NA-1:0][CB-1:0]   diff_d;
  logic [NA-1:0][CB-1:0]   diff_q;
  logic                    v0_q;
  logic [NA:0]             v_c;
  logic [NA:0][SUM_W-1:0]  s_c;
  logic [NA:0][NA-1:0][CB-1:0] d_c;

  always_comb begin
    logic signed [CB:0] ax;
    logic signed [CB:0] bx;
    for (int k = 0; k < NA; k++) begin
      ax = {a_i[k][CB-1], a_i[k]};
      bx = {b_i[k][CB-1], b_i[k]};
      diff_d[k] = (ax >= bx) ? CB'(ax - bx) : CB'(bx - ax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  assign v_c[0] = v0_q;
  assign s_c[0] = '0;
  assign d_c[0] = diff_q;

  for (genvar k = 0; k < NA; k++) begin : g_cell
    fofg_dist_cell #(
      .CB    (CB),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v_c[k]),
      .sum_i   (s_c[k]),
      .diff_i  (d_c[k]),
      .valid_o (v_c[k+1]),
      .sum_o   (s_c[k+1]),
      .diff_o  (d_c[k+1])
    );
  end

  assign done_o = v_c[NA];
  assign link_o = CMP_W'(s_c[NA]) < CMP_W'(link_len_i);

endmodule

/* rtl/core/friends_of_friends_grouper.sv */
// top level of the friends-of-friends grouper for the particles of one cell
// depends on fofg_pkg, fofg_ifs, fofg_ram and fofg_dist_chain
//
// usage:
//   cfg_i  : register writes (link_length_sq, edge_limit), always ready, one per cycle;
//            write only while the block is idle
//   item_i : opcode 0 loads one particle, one per cycle; the load with last_particle set
//            starts the grouping pass and item_i.ready stays low until it is finished
//   rec_o  : one record per fetch (opcode 1): group records, then one new-slot record per
//            original particle, then nothing-left records
// sequencing:
//   a load is written to the particle ram as it is taken; a fetch waits in S_FOUT until
//   the output register is free; the pass is sequential over one shared distance chain
//   and the particle ram port: each tested pair reads its candidate and runs the chain,
//   a linked one is swapped into the first unassigned place, then a sweep assigns slots
// reset: all counters cleared, block in the loading phase; rams are not cleared
// stall: a held record waits in the output register; the next item is still taken, and
//   a second fetch waits until the register is free
module friends_of_friends_grouper #(
  parameter int MAX_PARTICLES = fofg_pkg::DEF_MAX_PARTICLES,
  parameter int COORD_BITS    = fofg_pkg::DEF_COORD_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fofg_cfg_if.sink     cfg_i,
  fofg_item_if.sink    item_i,
  fofg_rec_if.source   rec_o
);

  localparam int CB     = COORD_BITS;
  localparam int NA     = fofg_pkg::AXES;
  localparam int IDX_W  = $clog2(MAX_PARTICLES);
  localparam int CNT_W  = $clog2(MAX_PARTICLES + 2);
  localparam int GMAX   = MAX_PARTICLES / 2;
  localparam int GA_W   = (GMAX > 1) ? $clog2(GMAX) : 1;
  localparam int GCNT_W = $clog2(GMAX + 1);
  localparam int CUR_W  = $clog2(MAX_PARTICLES + GMAX + 1);
  localparam int PW     = NA * CB + IDX_W;
  localparam int SPW    = IDX_W + CNT_W;
  localparam int BXW    = 2 * NA * CB;
  localparam int AB_W   = ((CB > fofg_pkg::EDGE_W) ? CB : fofg_pkg::EDGE_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FOUT = 4'd1;
  localparam logic [3:0] P_RDP  = 4'd2;
  localparam logic [3:0] P_LDP  = 4'd3;
  localparam logic [3:0] P_RDA  = 4'd4;
  localparam logic [3:0] P_LDA  = 4'd5;
  localparam logic [3:0] P_CH   = 4'd6;
  localparam logic [3:0] P_RDU  = 4'd7;
  localparam logic [3:0] P_SW1  = 4'd8;
  localparam logic [3:0] P_SW2  = 4'd9;
  localparam logic [3:0] P_END  = 4'd10;
  localparam logic [3:0] A_INIT = 4'd11;
  localparam logic [3:0] A_RDG  = 4'd12;
  localparam logic [3:0] A_LDG  = 4'd13;
  localparam logic [3:0] A_RDJ  = 4'd14;
  localparam logic [3:0] A_LDJ  = 4'd15;

  function automatic logic outside(input logic [CB-1:0] c,
                                   input logic [fofg_pkg::EDGE_W-1:0] e);
    logic signed [AB_W-1:0] w;
    logic [AB_W-1:0]        mag;
    w   = AB_W'($signed(c));
    mag = (w < 0) ? AB_W'(-w) : AB_W'(w);
    return mag > AB_W'(e);
  endfunction

  logic [3:0]                    state_q;
  logic [fofg_pkg::LINK_W-1:0]   link_q;
  logic [fofg_pkg::EDGE_W-1:0]   edge_q;
  logic [CNT_W-1:0]              n_q;
  logic [GCNT_W-1:0]             gc_q;
  logic                          outph_q;
  logic [CUR_W-1:0]              cursor_q;

  logic [CNT_W-1:0]              prim_q, unas_q, start_q, a_q, members_q;
  logic [NA-1:0][CB-1:0]         pc_q;
  logic [PW-1:0]                 cand_q, tmp_q;
  logic signed [CB-1:0]          bmin_q [NA];
  logic signed [CB-1:0]          bmax_q [NA];

  logic [CNT_W-1:0]              m_q, s_q, j_q, bnd_q, nstart_q, gend_q;
  logic [GCNT_W-1:0]             g_q;

  fofg_pkg::rec_kind_e           fkind_q;
  logic [IDX_W-1:0]              fj_q;
  logic                          flast_q;

  logic                          out_valid_q;
  logic [fofg_pkg::KIND_W-1:0]   kind_q;
  logic [fofg_pkg::FIRST_W-1:0]  first_q;
  logic [fofg_pkg::SECOND_W-1:0] second_q;
  logic signed [CB-1:0]          omin_q [NA];
  logic signed [CB-1:0]          omax_q [NA];
  logic                          olast_q;

  logic             in_acc, is_load, is_fetch, room, out_free;
  logic [CNT_W-1:0] n_eff;
  logic             cur_in_grp, slot_ok;
  logic [CUR_W-1:0] slot_j;
  logic [CNT_W-1:0] prim_nx, gsize, a_nx, j_nx;
  logic             close_grp;

  logic             p_we, p_re;
  logic [IDX_W-1:0] p_waddr, p_raddr;
  logic [PW-1:0]    p_wdata, p_rdata;
  logic             s_we, s_re;
  logic [GA_W-1:0]  s_waddr, s_raddr;
  logic [SPW-1:0]   s_wdata, s_rdata;
  logic             b_we, b_re;
  logic [BXW-1:0]   b_wdata, b_rdata;
  logic             n_we, n_re;
  logic [IDX_W-1:0] n_waddr, n_raddr, n_wdata, n_rdata;

  logic             ch_start, ch_done, ch_link;

  logic [NA-1:0][CB-1:0] rd_xyz;
  logic [IDX_W-1:0]      rd_org;
  logic [IDX_W-1:0]      sp_start;
  logic [CNT_W-1:0]      sp_size;
  logic                  member, bnd_flag;

  assign rd_xyz   = p_rdata[NA*CB-1:0];
  assign rd_org   = p_rdata[PW-1:NA*CB];
  assign sp_start = s_rdata[SPW-1:CNT_W];
  assign sp_size  = s_rdata[CNT_W-1:0];

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = (state_q == S_IDLE);
  assign in_acc       = item_i.valid & item_i.ready;
  assign is_load      = (item_i.opcode == fofg_pkg::OP_LOAD);
  assign is_fetch     = (item_i.opcode == fofg_pkg::OP_FETCH);
  assign n_eff        = outph_q ? '0 : n_q;
  assign room         = n_eff < CNT_W'(MAX_PARTICLES);
  assign out_free     = !out_valid_q || rec_o.ready;

  assign cur_in_grp = cursor_q < CUR_W'(gc_q);
  assign slot_j     = cursor_q - CUR_W'(gc_q);
  assign slot_ok    = slot_j < CUR_W'(n_q);

  assign prim_nx   = prim_q + 1'b1;
  assign gsize     = unas_q - start_q;
  assign close_grp = (prim_nx == unas_q) && (gsize > CNT_W'(1)) && (gc_q < GCNT_W'(GMAX));
  assign a_nx      = a_q + 1'b1;
  assign j_nx      = j_q + 1'b1;

  assign member   = !(j_q < nstart_q);
  assign bnd_flag = outside(rd_xyz[0], edge_q) | outside(rd_xyz[1], edge_q) |
                    outside(rd_xyz[2], edge_q);

  assign ch_start = (state_q == P_LDA);

  // ram port control
  always_comb begin
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
    s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
    b_we = 1'b0; b_wdata = '0; b_re = 1'b0;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
    case (state_q)
      S_IDLE: begin
        p_we    = in_acc & is_load & room;
        p_waddr = n_eff[IDX_W-1:0];
        p_wdata = {n_eff[IDX_W-1:0], item_i.pos_z, item_i.pos_y, item_i.pos_x};
        s_re    = in_acc & is_fetch & outph_q & cur_in_grp;
        b_re    = s_re;
        s_raddr = cursor_q[GA_W-1:0];
        n_re    = in_acc & is_fetch & outph_q & !cur_in_grp & slot_ok;
        n_raddr = slot_j[IDX_W-1:0];
      end
      P_RDP: begin
        p_re = 1'b1; p_raddr = prim_q[IDX_W-1:0];
      end
      P_RDA: begin
        p_re = 1'b1; p_raddr = a_q[IDX_W-1:0];
      end
      P_RDU: begin
        p_re = 1'b1; p_raddr = unas_q[IDX_W-1:0];
      end
      P_SW1: begin
        p_we = 1'b1; p_waddr = unas_q[IDX_W-1:0]; p_wdata = cand_q;
      end
      P_SW2: begin
        p_we = 1'b1; p_waddr = a_q[IDX_W-1:0]; p_wdata = tmp_q;
      end
      P_END: begin
        s_we    = close_grp;
        b_we    = close_grp;
        s_waddr = gc_q[GA_W-1:0];
        s_wdata = {start_q[IDX_W-1:0], gsize};
        b_wdata = {bmax_q[2], bmax_q[1], bmax_q[0], bmin_q[2], bmin_q[1], bmin_q[0]};
      end
      A_RDG: begin
        s_re = 1'b1; s_raddr = g_q[GA_W-1:0];
      end
      A_LDG: begin
        s_we    = (g_q < gc_q);
        s_waddr = g_q[GA_W-1:0];
        s_wdata = {m_q[IDX_W-1:0], sp_size};
      end
      A_RDJ: begin
        p_re = 1'b1; p_raddr = j_q[IDX_W-1:0];
      end
      A_LDJ: begin
        n_we    = 1'b1;
        n_waddr = rd_org;
        n_wdata = member ? m_q[IDX_W-1:0] : (bnd_flag ? bnd_q[IDX_W-1:0] : s_q[IDX_W-1:0]);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      link_q    <= '0;
      edge_q    <= '0;
      n_q       <= '0;
      gc_q      <= '0;
      outph_q   <= 1'b0;
      cursor_q  <= '0;
      prim_q    <= '0;
      unas_q    <= '0;
      start_q   <= '0;
      a_q       <= '0;
      members_q <= '0;
      m_q       <= '0;
      s_q       <= '0;
      j_q       <= '0;
      bnd_q     <= '0;
      nstart_q  <= '0;
      gend_q    <= '0;
      g_q       <= '0;
      fkind_q   <= fofg_pkg::KIND_NONE;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          fofg_pkg::CFG_LINK: link_q <= cfg_i.data;
          fofg_pkg::CFG_EDGE: edge_q <= cfg_i.data[fofg_pkg::EDGE_W-1:0];
          default: begin
          end
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && is_load) begin
            outph_q  <= 1'b0;
            cursor_q <= '0;
            n_q      <= room ? n_eff + 1'b1 : n_eff;
            gc_q     <= outph_q ? '0 : gc_q;
            if (item_i.last_particle) begin
              prim_q    <= '0;
              start_q   <= '0;
              unas_q    <= CNT_W'(1);
              gc_q      <= '0;
              members_q <= '0;
              state_q   <= P_RDP;
            end
          end else if (in_acc) begin
            state_q <= S_FOUT;
            if (!outph_q) begin
              fkind_q <= fofg_pkg::KIND_NONE;
            end else if (cur_in_grp) begin
              fkind_q  <= fofg_pkg::KIND_GROUP;
              cursor_q <= cursor_q + 1'b1;
            end else if (slot_ok) begin
              fkind_q  <= fofg_pkg::KIND_SLOT;
              cursor_q <= cursor_q + 1'b1;
            end else begin
              fkind_q <= fofg_pkg::KIND_NONE;
            end
          end
        end
        S_FOUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        P_RDP: state_q <= P_LDP;
        P_LDP: begin
          a_q     <= unas_q;
          state_q <= (unas_q < n_q) ? P_RDA : P_END;
        end
        P_RDA: state_q <= P_LDA;
        P_LDA: state_q <= P_CH;
        P_CH: begin
          if (ch_done) begin
            if (ch_link) begin
              state_q <= P_RDU;
            end else begin
              a_q     <= a_nx;
              state_q <= (a_nx < n_q) ? P_RDA : P_END;
            end
          end
        end
        P_RDU: state_q <= P_SW1;
        P_SW1: state_q <= P_SW2;
        P_SW2: begin
          unas_q  <= unas_q + 1'b1;
          a_q     <= a_nx;
          state_q <= (a_nx < n_q) ? P_RDA : P_END;
        end
        P_END: begin
          prim_q <= prim_nx;
          if (close_grp) begin
            gc_q      <= gc_q + 1'b1;
            members_q <= members_q + gsize;
          end
          if (prim_nx == unas_q) begin
            start_q <= prim_nx;
            unas_q  <= prim_nx + 1'b1;
          end
          state_q <= (prim_nx < n_q) ? P_RDP : A_INIT;
        end
        A_INIT: begin
          m_q     <= '0;
          j_q     <= '0;
          g_q     <= '0;
          s_q     <= n_q - 1'b1;
          bnd_q   <= members_q;
          state_q <= A_RDG;
        end
        A_RDG: state_q <= A_LDG;
        A_LDG: begin
          if (g_q < gc_q) begin
            nstart_q <= CNT_W'(sp_start);
            gend_q   <= CNT_W'(sp_start) + sp_size;
          end else begin
            nstart_q <= n_q;
            gend_q   <= n_q;
          end
          if (j_q < n_q) begin
            state_q <= A_RDJ;
          end else begin
            outph_q  <= 1'b1;
            cursor_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        A_RDJ: state_q <= A_LDJ;
        A_LDJ: begin
          j_q <= j_nx;
          if (member) begin
            m_q <= m_q + 1'b1;
          end else if (bnd_flag) begin
            bnd_q <= bnd_q + 1'b1;
          end else begin
            s_q <= s_q - 1'b1;
          end
          if (j_nx == n_q) begin
            outph_q  <= 1'b1;
            cursor_q <= '0;
            state_q  <= S_IDLE;
          end else if (member && (j_nx == gend_q)) begin
            g_q     <= g_q + 1'b1;
            state_q <= A_RDG;
          end else begin
            state_q <= A_RDJ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // pass data registers
  always_ff @(posedge clk_i) begin
    if (state_q == P_LDP) begin
      pc_q <= rd_xyz;
      if (prim_q == start_q) begin
        for (int k = 0; k < NA; k++) begin
          bmin_q[k] <= $signed(rd_xyz[k]);
          bmax_q[k] <= $signed(rd_xyz[k]);
        end
      end
    end
    if (state_q == P_LDA) begin
      cand_q <= p_rdata;
    end
    if (state_q == P_CH && ch_done && ch_link) begin
      for (int k = 0; k < NA; k++) begin
        if ($signed(cand_q[k*CB +: CB]) < bmin_q[k]) bmin_q[k] <= $signed(cand_q[k*CB +: CB]);
        if ($signed(cand_q[k*CB +: CB]) > bmax_q[k]) bmax_q[k] <= $signed(cand_q[k*CB +: CB]);
      end
    end
    if (state_q == P_SW1) begin
      tmp_q <= p_rdata;
    end
    if (state_q == S_IDLE && in_acc && is_fetch) begin
      fj_q    <= slot_j[IDX_W-1:0];
      flast_q <= (slot_j + 1'b1) == CUR_W'(n_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_FOUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rec_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FOUT && out_free) begin
      kind_q   <= fkind_q;
      first_q  <= '0;
      second_q <= '0;
      olast_q  <= 1'b0;
      for (int k = 0; k < NA; k++) begin
        omin_q[k] <= '0;
        omax_q[k] <= '0;
      end
      case (fkind_q)
        fofg_pkg::KIND_GROUP: begin
          first_q  <= fofg_pkg::FIRST_W'(sp_start);
          second_q <= fofg_pkg::SECOND_W'(sp_size);
          for (int k = 0; k < NA; k++) begin
            omin_q[k] <= $signed(b_rdata[k*CB +: CB]);
            omax_q[k] <= $signed(b_rdata[(NA+k)*CB +: CB]);
          end
        end
        fofg_pkg::KIND_SLOT: begin
          first_q  <= fofg_pkg::FIRST_W'(fj_q);
          second_q <= fofg_pkg::SECOND_W'(n_rdata);
          olast_q  <= flast_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign rec_o.valid        = out_valid_q;
  assign rec_o.record_kind  = kind_q;
  assign rec_o.first_value  = first_q;
  assign rec_o.second_value = second_q;
  assign rec_o.box_min_x    = omin_q[0];
  assign rec_o.box_min_y    = omin_q[1];
  assign rec_o.box_min_z    = omin_q[2];
  assign rec_o.box_max_x    = omax_q[0];
  assign rec_o.box_max_y    = omax_q[1];
  assign rec_o.box_max_z    = omax_q[2];
  assign rec_o.last_record  = olast_q;

  fofg_dist_chain #(
    .CB (CB)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ch_start),
    .a_i        (pc_q),
    .b_i        (rd_xyz),
    .link_len_i (link_q),
    .done_o     (ch_done),
    .link_o     (ch_link)
  );

  fofg_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_part_ram (
    .clk_i (clk_i), .we_i (p_we), .waddr_i (p_waddr), .wdata_i (p_wdata),
    .re_i (p_re), .raddr_i (p_raddr), .rdata_o (p_rdata)
  );

  fofg_ram #(.WIDTH(SPW), .DEPTH(GMAX)) u_span_ram (
    .clk_i (clk_i), .we_i (s_we), .waddr_i (s_waddr), .wdata_i (s_wdata),
    .re_i (s_re), .raddr_i (s_raddr), .rdata_o (s_rdata)
  );

  fofg_ram #(.WIDTH(BXW), .DEPTH(GMAX)) u_box_ram (
    .clk_i (clk_i), .we_i (b_we), .waddr_i (s_waddr), .wdata_i (b_wdata),
    .re_i (b_re), .raddr_i (s_raddr), .rdata_o (b_rdata)
  );

  fofg_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PARTICLES)) u_slot_ram (
    .clk_i (clk_i), .we_i (n_we), .waddr_i (n_waddr), .wdata_i (n_wdata),
    .re_i (n_re), .raddr_i (n_raddr), .rdata_o (n_rdata)
  );

  a_out_from_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FOUT)
    else $error("record shown without a fetch");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == P_RDA |-> (unas_q > prim_q) && (a_q >= unas_q) && (a_q < n_q))
    else $error("candidate scan out of order");

  a_group_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gc_q <= GCNT_W'(GMAX))
    else $error("group count beyond capacity");

  a_members: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == A_LDJ |-> members_q <= n_q)
    else $error("member total exceeds particle count");

endmodule
